// ----- rtl/byte_ring_buffer_manager_defines.svh -----
// ----------------------------------------------------------------------------
// Byte ring buffer manager assertion macros
// Shared assertion forms for the ring buffer checkers.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_MANAGER_DEFINES_SVH
`define BYTE_RING_BUFFER_MANAGER_DEFINES_SVH

// Checked only while the block is out of reset.
`define BRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BRB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Word types, request and status codes, and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brb_pkg;

    // The buffer length must be a multiple of the word size.
    localparam int BUF_BYTES_DEF = 4096;
    localparam int WORD_BYTES    = 4;
    localparam int LANE_W        = $clog2(WORD_BYTES);
    localparam int DATA_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 13;
    localparam int POS_W         = 12;

    typedef enum logic [1:0] {
        REQ_PUSH         = 2'd0,
        REQ_COMMIT_READ  = 2'd1,
        REQ_COMMIT_WRITE = 2'd2,
        REQ_READ_BYTE    = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type            req_type;
        logic [DATA_W-1:0]    push_word;
        logic [COUNT_W-1:0]   commit_bytes;
        logic [POS_W-1:0]     byte_offset;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [BYTE_W-1:0]    read_byte;
        logic [COUNT_W-1:0]   bytes_used;
        logic [COUNT_W-1:0]   bytes_free;
        logic [COUNT_W-1:0]   contiguous_free;
        logic [COUNT_W-1:0]   contiguous_used;
        logic [POS_W-1:0]     read_position;
        logic [POS_W-1:0]     write_position;
    } t_rsp;

    typedef struct packed {
        t_req_type            req_type;
        t_status              status;
    } t_item_ctl;

endpackage

// ----- rtl/brb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/brb_update.sv -----
// ----------------------------------------------------------------------------
// Ring buffer pointer update
// Input register, pointer and fill state, and the byte lane writes of a push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_update import brb_pkg::*; #(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int PTR_W = $clog2(BUF_BYTES),
    localparam int CNT_W = $clog2(BUF_BYTES + 1),
    localparam int ROW_W = PTR_W - LANE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_req                 i_req,
    input  logic                 i_fire,
    output logic [WORD_BYTES-1:0] o_wr_en,
    output logic [ROW_W-1:0]     o_wr_row [WORD_BYTES],
    output logic [BYTE_W-1:0]    o_wr_data [WORD_BYTES],
    output t_item_ctl            o_ctl,
    output logic [POS_W-1:0]     o_offset,
    output logic [POS_W-1:0]     o_quot,
    output logic [PTR_W-1:0]     o_rp,
    output logic [PTR_W-1:0]     o_wp,
    output logic [CNT_W-1:0]     o_fill
);

    localparam int SUM_W   = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int QPROD_W = 2 * POS_W + 1;
    localparam int RCP_SH  = POS_W + $clog2(BUF_BYTES);
    localparam longint RCP_MUL = ((64'd1 << RCP_SH) + BUF_BYTES - 1) / BUF_BYTES;

    t_req               r_req;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W-1:0]   r_wp;
    logic [CNT_W-1:0]   r_fill;
    logic [PTR_W-1:0]   n_rp;
    logic [PTR_W-1:0]   n_wp;
    logic [CNT_W-1:0]   n_fill;
    logic [PTR_W-1:0]   base;
    logic [SUM_W-1:0]   fill_x;
    logic [SUM_W-1:0]   n_x;
    logic [SUM_W-1:0]   buf_x;
    logic               empty;
    logic               push_ok;
    logic               do_push;
    t_status            status;
    logic [LANE_W-1:0]  lane_off [WORD_BYTES];
    logic [PTR_W-1:0]   lane_addr [WORD_BYTES];
    logic [QPROD_W-1:0] quot_prod;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                   input logic [SUM_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + k;
        if (s >= SUM_W'(BUF_BYTES)) begin
            s = s - SUM_W'(BUF_BYTES);
        end
        return s[PTR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_fire) begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_comb begin
        fill_x  = SUM_W'(r_fill);
        n_x     = SUM_W'(r_req.commit_bytes);
        buf_x   = SUM_W'(BUF_BYTES);
        empty   = (r_fill == '0);
        push_ok = empty || (fill_x + SUM_W'(WORD_BYTES) <= buf_x);
        base    = empty ? '0 : r_wp;
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_fill  = r_fill;
        status  = ST_OK;
        do_push = 1'b0;
        case (r_req.req_type)
            REQ_PUSH: begin
                if (push_ok) begin
                    do_push = 1'b1;
                    n_rp    = empty ? '0 : r_rp;
                    n_wp    = wrap_add(base, SUM_W'(WORD_BYTES));
                    n_fill  = CNT_W'(fill_x + SUM_W'(WORD_BYTES));
                end else begin
                    status = ST_FULL;
                end
            end
            REQ_COMMIT_READ: begin
                if (n_x > fill_x) begin
                    status = ST_UNDER;
                end else if (n_x == fill_x) begin
                    n_rp   = '0;
                    n_wp   = '0;
                    n_fill = '0;
                end else begin
                    n_rp   = wrap_add(r_rp, n_x);
                    n_fill = CNT_W'(fill_x - n_x);
                end
            end
            REQ_COMMIT_WRITE: begin
                if (fill_x + n_x > buf_x) begin
                    status = ST_FULL;
                end else begin
                    n_rp   = empty ? '0 : r_rp;
                    n_wp   = wrap_add(base, n_x);
                    n_fill = CNT_W'(fill_x + n_x);
                end
            end
            REQ_READ_BYTE: begin
            end
            default: begin
            end
        endcase

        for (int b = 0; b < WORD_BYTES; b++) begin
            lane_off[b]  = LANE_W'(b) - base[LANE_W-1:0];
            lane_addr[b] = wrap_add(base, SUM_W'(lane_off[b]));
            o_wr_en[b]   = i_fire && do_push;
            o_wr_row[b]  = lane_addr[b][PTR_W-1:LANE_W];
            o_wr_data[b] = BYTE_W'(r_req.push_word >> {lane_off[b], 3'b000});
        end

        quot_prod = QPROD_W'(r_req.byte_offset) * QPROD_W'(RCP_MUL);
        o_quot    = POS_W'(quot_prod >> RCP_SH);
    end

    assign o_ctl.req_type = r_req.req_type;
    assign o_ctl.status   = status;
    assign o_offset       = r_req.byte_offset;
    assign o_rp           = n_rp;
    assign o_wp           = n_wp;
    assign o_fill         = n_fill;

endmodule

// ----- rtl/brb_report.sv -----
// ----------------------------------------------------------------------------
// Ring buffer space report
// Space figures, read address reduction, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_report import brb_pkg::*; #(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int PTR_W = $clog2(BUF_BYTES),
    localparam int CNT_W = $clog2(BUF_BYTES + 1),
    localparam int ROW_W = PTR_W - LANE_W
) (
    input  logic              i_clk,
    input  logic              i_load2,
    input  logic              i_load3,
    input  t_item_ctl         i_ctl,
    input  logic [POS_W-1:0]  i_offset,
    input  logic [POS_W-1:0]  i_quot,
    input  logic [PTR_W-1:0]  i_rp,
    input  logic [PTR_W-1:0]  i_wp,
    input  logic [CNT_W-1:0]  i_fill,
    output logic              o_rd_en,
    output logic [ROW_W-1:0]  o_rd_row,
    input  logic [BYTE_W-1:0] i_rd_data [WORD_BYTES],
    output t_rsp              o_rsp
);

    localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int MOD_W = POS_W + CNT_W;

    t_item_ctl          r_s2_ctl;
    logic [POS_W-1:0]   r_s2_off;
    logic [POS_W-1:0]   r_s2_quot;
    logic [PTR_W-1:0]   r_s2_rp;
    logic [PTR_W-1:0]   r_s2_wp;
    logic [CNT_W-1:0]   r_s2_fill;
    t_rsp               r_s3;
    logic [LANE_W-1:0]  r_s3_lane;
    logic               r_s3_is_read;
    logic [SUM_W-1:0]   fill_x;
    logic [SUM_W-1:0]   rp_x;
    logic [SUM_W-1:0]   wp_x;
    logic [SUM_W-1:0]   buf_x;
    logic [SUM_W-1:0]   cfree;
    logic [SUM_W-1:0]   cused;
    logic [SUM_W-1:0]   bfree;
    logic [MOD_W-1:0]   rem;
    logic [PTR_W-1:0]   rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_load2) begin
            r_s2_ctl  <= i_ctl;
            r_s2_off  <= i_offset;
            r_s2_quot <= i_quot;
            r_s2_rp   <= i_rp;
            r_s2_wp   <= i_wp;
            r_s2_fill <= i_fill;
        end
    end

    always_comb begin
        fill_x = SUM_W'(r_s2_fill);
        rp_x   = SUM_W'(r_s2_rp);
        wp_x   = SUM_W'(r_s2_wp);
        buf_x  = SUM_W'(BUF_BYTES);
        bfree  = buf_x - fill_x;

        if (r_s2_wp > r_s2_rp && r_s2_fill != '0) begin
            cfree = buf_x - wp_x;
        end else if (r_s2_wp < r_s2_rp) begin
            cfree = rp_x - wp_x;
        end else if (r_s2_fill != '0) begin
            cfree = '0;
        end else begin
            cfree = buf_x;
        end

        if (r_s2_wp > r_s2_rp) begin
            cused = fill_x;
        end else if (r_s2_wp < r_s2_rp || r_s2_fill != '0) begin
            cused = buf_x - rp_x;
        end else begin
            cused = '0;
        end

        rem     = MOD_W'(r_s2_off) - MOD_W'(r_s2_quot) * MOD_W'(BUF_BYTES);
        rd_addr = rem[PTR_W-1:0];
    end

    assign o_rd_en  = i_load3;
    assign o_rd_row = rd_addr[PTR_W-1:LANE_W];

    always_ff @(posedge i_clk) begin
        if (i_load3) begin
            r_s3.status          <= r_s2_ctl.status;
            r_s3.read_byte       <= '0;
            r_s3.bytes_used      <= fill_x[COUNT_W-1:0];
            r_s3.bytes_free      <= bfree[COUNT_W-1:0];
            r_s3.contiguous_free <= cfree[COUNT_W-1:0];
            r_s3.contiguous_used <= cused[COUNT_W-1:0];
            r_s3.read_position   <= rp_x[POS_W-1:0];
            r_s3.write_position  <= wp_x[POS_W-1:0];
            r_s3_lane            <= rd_addr[LANE_W-1:0];
            r_s3_is_read         <= (r_s2_ctl.req_type == REQ_READ_BYTE);
        end
    end

    always_comb begin
        o_rsp           = r_s3;
        o_rsp.read_byte = r_s3_is_read ? i_rd_data[r_s3_lane] : '0;
    end

endmodule

// ----- rtl/byte_ring_buffer_manager.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer manager
// Byte-addressed ring buffer with word push, commits, byte reads and
// space reporting.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_stall   i_req (t_req)
//  result    out        o_valid / i_stall   o_rsp (t_rsp)
//
// Once a request is accepted, the pointer update works out of the input
// register into a middle register, then the byte-banked store is read with a
// registered read into the result register. One word may be accepted every
// cycle while o_stall is low; each stage moves up into a free slot. Synchronous
// reset empties the buffer and the pipeline; the store is not cleared. o_stall
// rises only when all three stages are full and the result is stalled.
`timescale 1ns / 1ps

module byte_ring_buffer_manager import brb_pkg::*; #(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    output t_rsp o_rsp,
    input  logic i_stall
);

    localparam int PTR_W      = $clog2(BUF_BYTES);
    localparam int CNT_W      = $clog2(BUF_BYTES + 1);
    localparam int ROW_W      = PTR_W - LANE_W;
    localparam int BANK_DEPTH = BUF_BYTES / WORD_BYTES;

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic                  en1;
    logic                  en2;
    logic                  en3;
    logic                  fire;
    logic [WORD_BYTES-1:0] wr_en;
    logic [ROW_W-1:0]      wr_row [WORD_BYTES];
    logic [BYTE_W-1:0]     wr_data [WORD_BYTES];
    logic [BYTE_W-1:0]     rd_data [WORD_BYTES];
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_row;
    t_item_ctl             ctl;
    logic [POS_W-1:0]      offset;
    logic [POS_W-1:0]      quot;
    logic [PTR_W-1:0]      rp;
    logic [PTR_W-1:0]      wp;
    logic [CNT_W-1:0]      fill;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign fire    = r_v1 && en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    brb_update #(.BUF_BYTES(BUF_BYTES)) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (en1),
        .i_req     (i_req),
        .i_fire    (fire),
        .o_wr_en   (wr_en),
        .o_wr_row  (wr_row),
        .o_wr_data (wr_data),
        .o_ctl     (ctl),
        .o_offset  (offset),
        .o_quot    (quot),
        .o_rp      (rp),
        .o_wp      (wp),
        .o_fill    (fill)
    );

    for (genvar g = 0; g < WORD_BYTES; g++) begin : g_bank
        brb_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_row[g]),
            .i_wr_data (wr_data[g]),
            .i_rd_en   (rd_en),
            .i_rd_addr (rd_row),
            .o_rd_data (rd_data[g])
        );
    end

    brb_report #(.BUF_BYTES(BUF_BYTES)) u_report (
        .i_clk     (i_clk),
        .i_load2   (en2),
        .i_load3   (en3),
        .i_ctl     (ctl),
        .i_offset  (offset),
        .i_quot    (quot),
        .i_rp      (rp),
        .i_wp      (wp),
        .i_fill    (fill),
        .o_rd_en   (rd_en),
        .o_rd_row  (rd_row),
        .i_rd_data (rd_data),
        .o_rsp     (o_rsp)
    );

endmodule

// ----- rtl/brb_chk.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer manager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_ring_buffer_manager_defines.svh"

module brb_chk import brb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input t_req i_req,
    input logic o_stall,
    input logic o_valid,
    input t_rsp o_rsp,
    input logic i_stall
);

    `BRB_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")

    `BRB_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_rsp), "stalled word changed")

    `BRB_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without output stall")

    `BRB_ASSERT(a_empty_rewound, o_valid && o_rsp.bytes_used == '0 |-> o_rsp.read_position == '0 && o_rsp.write_position == '0 && o_rsp.contiguous_used == '0, "empty buffer not rewound")

endmodule

bind byte_ring_buffer_manager brb_chk u_chk (.*);

// ----- dv/byte_ring_buffer_manager_tb.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer manager testbench
// Drives push, commit and byte-read requests and checks every result word
// field by field against a typed table response or else a behavioral ring
// model kept in step with the accepted requests. A directed table covers the
// empty, full, wrap and rejection cases, then biased random traffic runs with
// random idling on both sides, a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_manager_tb import brb_pkg::*;;

    localparam int unsigned DEPTH        = BUF_BYTES_DEF;
    localparam int          RANDOM_ITEMS = 1125;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 80;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    t_req i_req;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;
    logic i_stall = 1'b0;

    byte_ring_buffer_manager dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Ring model state.
    bit [7:0]    ring_mem [DEPTH];
    bit          ring_written [DEPTH];
    int unsigned ring_rd;
    int unsigned ring_wr;
    int unsigned ring_fill;
    int unsigned last_push_at;
    bit          any_pushed;

    t_rsp        expected_rsps [$];
    t_plan_row   plan [$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned full_rejects;
    int unsigned under_rejects;
    int unsigned split_pushes;
    int unsigned byte_reads;
    int unsigned times_full;
    int unsigned times_empty;
    int unsigned hold_asked;
    int unsigned hold_served;
    int unsigned hold_left;
    bit          no_idle;

    function automatic int unsigned ring_wrap(int unsigned p);
        return (p >= DEPTH) ? p - DEPTH : p;
    endfunction

    function automatic void ring_store_word(logic [31:0] w);
        if (ring_wr > DEPTH - 4) split_pushes++;
        for (int i = 0; i < 4; i++) begin
            ring_mem[ring_wr]     = w[8*i +: 8];
            ring_written[ring_wr] = 1'b1;
            last_push_at          = ring_wr;
            ring_wr               = ring_wrap(ring_wr + 1);
        end
        any_pushed = 1'b1;
    endfunction

    function automatic t_rsp ring_apply(t_req r);
        t_rsp        o;
        int unsigned n;
        int unsigned prev_fill;
        o         = '0;
        o.status  = ST_OK;
        n         = r.commit_bytes;
        prev_fill = ring_fill;
        case (r.req_type)
            REQ_PUSH: begin
                if (ring_fill == 0) begin
                    ring_rd = 0;
                    ring_wr = 0;
                    ring_store_word(r.push_word);
                    ring_fill = 4;
                end else if (ring_fill + 4 > DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    ring_store_word(r.push_word);
                    ring_fill += 4;
                end
            end
            REQ_COMMIT_READ: begin
                if (n > ring_fill) begin
                    o.status = ST_UNDER;
                end else begin
                    ring_rd   = ring_wrap(ring_rd + n);
                    ring_fill -= n;
                    if (ring_fill == 0) begin
                        ring_rd = 0;
                        ring_wr = 0;
                    end
                end
            end
            REQ_COMMIT_WRITE: begin
                if (ring_fill + n > DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    if (ring_fill == 0) begin
                        ring_rd = 0;
                        ring_wr = 0;
                    end
                    ring_wr   = ring_wrap(ring_wr + n);
                    ring_fill += n;
                end
            end
            default: begin
                o.read_byte = ring_mem[r.byte_offset % DEPTH];
                byte_reads++;
            end
        endcase
        if (o.status == ST_FULL) full_rejects++;
        if (o.status == ST_UNDER) under_rejects++;
        if (prev_fill != DEPTH && ring_fill == DEPTH) times_full++;
        if (prev_fill != 0 && ring_fill == 0) times_empty++;

        o.bytes_used = ring_fill;
        o.bytes_free = DEPTH - ring_fill;
        if (ring_wr > ring_rd && ring_fill != 0) o.contiguous_free = DEPTH - ring_wr;
        else if (ring_wr < ring_rd)              o.contiguous_free = ring_rd - ring_wr;
        else if (ring_fill != 0)                 o.contiguous_free = 0;
        else                                     o.contiguous_free = DEPTH;
        if (ring_wr > ring_rd)       o.contiguous_used = ring_fill;
        else if (ring_wr < ring_rd)  o.contiguous_used = DEPTH - ring_rd;
        else if (ring_fill != 0)     o.contiguous_used = DEPTH - ring_rd;
        else                         o.contiguous_used = 0;
        o.read_position  = ring_rd;
        o.write_position = ring_wr;
        return o;
    endfunction

    // Random request shaped by the current fill. Byte reads only target
    // offsets that a push has written.
    function automatic t_req ring_pick(bit noisy);
        t_req        r;
        int unsigned roll;
        int unsigned probe;
        int unsigned room;
        r.push_word    = $urandom;
        r.commit_bytes = $urandom_range(8191);
        r.byte_offset  = $urandom_range(DEPTH - 1);
        roll           = $urandom_range(99);
        if (roll < 40)      r.req_type = REQ_PUSH;
        else if (roll < 60) r.req_type = REQ_COMMIT_READ;
        else if (roll < 75) r.req_type = REQ_COMMIT_WRITE;
        else                r.req_type = REQ_READ_BYTE;

        if (r.req_type == REQ_READ_BYTE) begin
            if (!any_pushed) begin
                r.req_type = REQ_PUSH;
            end else begin
                r.byte_offset = last_push_at;
                if (ring_fill != 0) begin
                    probe = ring_wrap(ring_rd + $urandom_range(ring_fill - 1));
                    if (ring_written[probe]) r.byte_offset = probe;
                end
                probe = $urandom_range(DEPTH - 1);
                if ($urandom_range(1) == 1 && ring_written[probe]) r.byte_offset = probe;
            end
        end else if (!noisy && r.req_type != REQ_PUSH) begin
            room = (r.req_type == REQ_COMMIT_READ) ? ring_fill : DEPTH - ring_fill;
            roll = $urandom_range(99);
            if (roll < 15)      r.commit_bytes = room;
            else if (roll < 65) r.commit_bytes = $urandom_range((room < 64) ? room : 64);
            else                r.commit_bytes = $urandom_range(room);
        end
        return r;
    endfunction

    function automatic t_rsp rsp_of(t_status s, int rb, int used, int free_b, int cf,
                                     int cu, int rp, int wp);
        t_rsp o;
        o.status          = s;
        o.read_byte       = rb;
        o.bytes_used      = used;
        o.bytes_free      = free_b;
        o.contiguous_free = cf;
        o.contiguous_used = cu;
        o.read_position   = rp;
        o.write_position  = wp;
        return o;
    endfunction

    task automatic add_row(t_req_type op, logic [31:0] w, int n, int off,
                           bit typed = 1'b0, t_rsp rsp = '0);
        t_plan_row row;
        row.req.req_type     = op;
        row.req.push_word    = w;
        row.req.commit_bytes = n;
        row.req.byte_offset  = off;
        row.typed            = typed;
        row.rsp              = rsp;
        plan.push_back(row);
    endtask

    task automatic send_word(t_req r, bit typed, t_rsp typed_rsp, bit eager);
        t_rsp pred;
        if (!eager && !no_idle) begin
            while ($urandom_range(99) < 36) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        pred = ring_apply(r);
        expected_rsps.push_back(typed ? typed_rsp : pred);
        words_sent++;
    endtask

    function automatic void field_check(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    // Result side: checks, random stalls and the long hold-off.
    always @(posedge i_clk) begin
        t_rsp exp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatches++;
            end else begin
                exp = expected_rsps.pop_front();
                field_check("status", exp.status, o_rsp.status);
                field_check("read_byte", exp.read_byte, o_rsp.read_byte);
                field_check("bytes_used", exp.bytes_used, o_rsp.bytes_used);
                field_check("bytes_free", exp.bytes_free, o_rsp.bytes_free);
                field_check("contiguous_free", exp.contiguous_free, o_rsp.contiguous_free);
                field_check("contiguous_used", exp.contiguous_used, o_rsp.contiguous_used);
                field_check("read_position", exp.read_position, o_rsp.read_position);
                field_check("write_position", exp.write_position, o_rsp.write_position);
                words_checked++;
            end
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !no_idle && ($urandom_range(99) < 36);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_rsps.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;

        add_row(REQ_COMMIT_READ, 0, 0, 0, 1, rsp_of(ST_OK, 0, 0, 4096, 4096, 0, 0, 0));
        add_row(REQ_COMMIT_READ, 0, 1, 0, 1, rsp_of(ST_UNDER, 0, 0, 4096, 4096, 0, 0, 0));
        add_row(REQ_PUSH, 32'hFFFF_FFFF, 0, 0, 1, rsp_of(ST_OK, 0, 4, 4092, 4092, 4, 0, 4));
        add_row(REQ_READ_BYTE, 0, 0, 0, 1, rsp_of(ST_OK, 8'hFF, 4, 4092, 4092, 4, 0, 4));
        add_row(REQ_PUSH, 32'h0000_0000, 8191, 4095);
        add_row(REQ_READ_BYTE, 0, 0, 7);
        add_row(REQ_COMMIT_WRITE, 0, 4096, 0, 1, rsp_of(ST_FULL, 0, 8, 4088, 4088, 8, 0, 8));
        add_row(REQ_COMMIT_READ, 0, 8, 0, 1, rsp_of(ST_OK, 0, 0, 4096, 4096, 0, 0, 0));
        add_row(REQ_COMMIT_WRITE, 0, 4096, 0, 1, rsp_of(ST_OK, 0, 4096, 0, 0, 4096, 0, 0));
        add_row(REQ_PUSH, 32'h5A5A_A5A5, 0, 0, 1, rsp_of(ST_FULL, 0, 4096, 0, 0, 4096, 0, 0));
        add_row(REQ_COMMIT_WRITE, 0, 0, 0);
        add_row(REQ_COMMIT_READ, 0, 4096, 0, 1, rsp_of(ST_OK, 0, 0, 4096, 4096, 0, 0, 0));
        add_row(REQ_COMMIT_WRITE, 0, 4094, 0);
        add_row(REQ_COMMIT_READ, 0, 4000, 0);
        add_row(REQ_PUSH, 32'h1234_5678, 0, 0);
        add_row(REQ_READ_BYTE, 0, 0, 4094);
        add_row(REQ_READ_BYTE, 0, 0, 4095);
        add_row(REQ_READ_BYTE, 0, 0, 0);
        add_row(REQ_READ_BYTE, 0, 0, 1);
        add_row(REQ_COMMIT_READ, 0, 98, 0);
        add_row(REQ_COMMIT_WRITE, 0, 0, 0);
        add_row(REQ_COMMIT_WRITE, 0, 4092, 0);
        add_row(REQ_PUSH, 32'hDEAD_BEEF, 0, 0);
        add_row(REQ_READ_BYTE, 0, 0, 4095);
        add_row(REQ_COMMIT_READ, 0, 8191, 0, 1, rsp_of(ST_UNDER, 0, 4096, 0, 0, 4096, 0, 0));
        add_row(REQ_COMMIT_WRITE, 0, 8191, 0, 1, rsp_of(ST_FULL, 0, 4096, 0, 0, 4096, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) send_word(plan[i].req, plan[i].typed, plan[i].rsp, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) hold_asked++;
            if (i == 600) begin
                i_valid <= 1'b0;
                while (expected_rsps.size() != 0) @(posedge i_clk);
            end
            no_idle = (i >= 700 && i < 850);
            send_word(ring_pick($urandom_range(99) < 15), 1'b0, '0, i >= 300 && i < 340);
        end
        i_valid <= 1'b0;

        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests (%0d from the directed table), checked %0d results.",
                 words_sent, plan.size(), words_checked);
        $display("Saw %0d full and %0d underflow rejections, %0d split pushes, %0d byte reads, %0d fills, %0d drains.",
                 full_rejects, under_rejects, split_pushes, byte_reads, times_full, times_empty);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_update.sv
rtl/brb_report.sv
rtl/byte_ring_buffer_manager.sv
rtl/brb_chk.sv
dv/byte_ring_buffer_manager_tb.sv
